// File: hw/rtl/soarb_pkg.sv
// Shared constants and types for the starvation-aware oldest-first arbiter.
package soarb_pkg;

    // Default sizing of the arbiter.
    localparam int NUM_ACTORS_DEF = 16;
    localparam int TIME_WIDTH_DEF = 32;

    // Fixed port field widths.
    localparam int MASK_W  = 16;
    localparam int TIME_IN_W = 32;
    localparam int LIMIT_W = 32;
    localparam int ID_W    = 4;

    // Starvation limit after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1000;

    // Grant reason codes.
    localparam logic REASON_FIRST  = 1'b0;
    localparam logic REASON_OLDEST = 1'b1;

    // One arbitration result.
    typedef struct packed {
        logic            grant_valid;
        logic [ID_W-1:0] grant_id;
        logic            grant_reason;
    } t_result;

endpackage

// File: hw/rtl/soarb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module soarb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/soarb_ctrl.sv
// Scan sequencer and grant decision for the starvation-aware arbiter.
module soarb_ctrl #(
    parameter int NUM_ACTORS = soarb_pkg::NUM_ACTORS_DEF,
    parameter int TIME_WIDTH = soarb_pkg::TIME_WIDTH_DEF,
    localparam int SCAN_N = (NUM_ACTORS < soarb_pkg::MASK_W) ? NUM_ACTORS
                                                             : soarb_pkg::MASK_W,
    localparam int SIDX_W = $clog2(SCAN_N)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // New item from the input channel.
    input  logic                            i_start,
    input  logic [soarb_pkg::MASK_W-1:0]    i_mask,
    input  logic [soarb_pkg::TIME_IN_W-1:0] i_now,
    input  logic [soarb_pkg::LIMIT_W-1:0]   i_limit,
    output logic                            o_idle,
    // Finished result toward the output register.
    output logic                            o_res_valid,
    output soarb_pkg::t_result              o_res,
    input  logic                            i_res_take,
    // Timestamp memory port.
    output logic                            o_rd_en,
    output logic [SIDX_W-1:0]               o_rd_addr,
    input  logic [TIME_WIDTH-1:0]           i_rd_data,
    output logic                            o_wr_en,
    output logic [SIDX_W-1:0]               o_wr_addr,
    output logic [TIME_WIDTH-1:0]           o_wr_data
);

    localparam int CNT_W = $clog2(SCAN_N + 1);
    localparam int CMP_W = (TIME_WIDTH > soarb_pkg::LIMIT_W) ? TIME_WIDTH
                                                            : soarb_pkg::LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state,      n_state;
    logic [SCAN_N-1:0]   r_mask,       n_mask;
    logic [TIME_WIDTH-1:0] r_now,      n_now;
    logic [CNT_W-1:0]    r_rd_cnt,     n_rd_cnt;
    logic                r_ev_vld,     n_ev_vld;
    logic [SIDX_W-1:0]   r_ev_idx,     n_ev_idx;
    logic                r_have,       n_have;
    logic [SIDX_W-1:0]   r_best_idx,   n_best_idx;
    logic [TIME_WIDTH-1:0] r_best_age, n_best_age;
    logic                r_win_valid,  n_win_valid;
    logic [SIDX_W-1:0]   r_win_idx,    n_win_idx;
    logic                r_win_reason, n_win_reason;
    logic [SCAN_N-1:0]   r_ever,       n_ever;

    logic                  rd_en;
    logic [SIDX_W-1:0]     rd_addr;
    logic                  wr_en;
    logic                  ev_req;
    logic [TIME_WIDTH-1:0] ev_age;
    logic                  ev_starved;
    logic                  ev_first;
    logic                  ev_better;
    logic                  ev_last;

    // Read issue: one actor's timestamp per cycle during the scan.
    assign rd_en   = (r_state == S_SCAN) && (r_rd_cnt < CNT_W'(SCAN_N));
    assign rd_addr = r_rd_cnt[SIDX_W-1:0];

    // The write-back happens only when the result leaves, so it never
    // overlaps a read of the same item or of the next one.
    assign wr_en = (r_state == S_DONE) && i_res_take && r_win_valid;

    // Evaluation of the actor whose timestamp arrived this cycle.
    always_comb begin
        ev_req     = r_ev_vld && r_mask[r_ev_idx];
        ev_age     = r_now - i_rd_data;
        ev_starved = CMP_W'(ev_age) > CMP_W'(i_limit);
        ev_first   = ev_req && (!r_ever[r_ev_idx] || ev_starved);
        ev_better  = ev_req && (!r_have || (ev_age > r_best_age));
        ev_last    = r_ev_vld && (r_ev_idx == SIDX_W'(SCAN_N - 1));
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state      = r_state;
        n_mask       = r_mask;
        n_now        = r_now;
        n_rd_cnt     = r_rd_cnt;
        n_ev_vld     = r_ev_vld;
        n_ev_idx     = r_ev_idx;
        n_have       = r_have;
        n_best_idx   = r_best_idx;
        n_best_age   = r_best_age;
        n_win_valid  = r_win_valid;
        n_win_idx    = r_win_idx;
        n_win_reason = r_win_reason;
        n_ever       = r_ever;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mask     = i_mask[SCAN_N-1:0];
                    n_now      = TIME_WIDTH'(i_now);
                    n_rd_cnt   = '0;
                    n_ev_vld   = 1'b0;
                    n_ev_idx   = '0;
                    n_have     = 1'b0;
                    n_best_idx = '0;
                    n_best_age = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_cnt = r_rd_cnt + CNT_W'(1);
                end
                n_ev_vld = rd_en;
                n_ev_idx = rd_addr;
                if (ev_first) begin
                    // Never granted or starved: wins at once.
                    n_win_valid  = 1'b1;
                    n_win_idx    = r_ev_idx;
                    n_win_reason = soarb_pkg::REASON_FIRST;
                    n_state      = S_DONE;
                end else begin
                    if (ev_better) begin
                        n_have     = 1'b1;
                        n_best_idx = r_ev_idx;
                        n_best_age = ev_age;
                    end
                    if (ev_last) begin
                        n_win_valid  = r_have || ev_better;
                        n_win_idx    = ev_better ? r_ev_idx : r_best_idx;
                        n_win_reason = (r_have || ev_better) ? soarb_pkg::REASON_OLDEST
                                                             : soarb_pkg::REASON_FIRST;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    if (r_win_valid) begin
                        n_ever[r_win_idx] = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ev_vld <= 1'b0;
            r_ever   <= '0;
            r_rd_cnt <= '0;
            r_have   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= n_ev_vld;
            r_ever   <= n_ever;
            r_rd_cnt <= n_rd_cnt;
            r_have   <= n_have;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mask       <= n_mask;
        r_now        <= n_now;
        r_ev_idx     <= n_ev_idx;
        r_best_idx   <= n_best_idx;
        r_best_age   <= n_best_age;
        r_win_valid  <= n_win_valid;
        r_win_idx    <= n_win_idx;
        r_win_reason <= n_win_reason;
    end

    // Outputs.
    assign o_idle                = (r_state == S_IDLE);
    assign o_res_valid           = (r_state == S_DONE);
    assign o_res.grant_valid     = r_win_valid;
    assign o_res.grant_id        = soarb_pkg::ID_W'(r_win_idx);
    assign o_res.grant_reason    = r_win_reason;
    assign o_rd_en               = rd_en;
    assign o_rd_addr             = rd_addr;
    assign o_wr_en               = wr_en;
    assign o_wr_addr             = r_win_idx;
    assign o_wr_data             = r_now;

    // A write-back and a timestamp read never share a cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("timestamp write and read in the same cycle");

    // An empty grant always reports actor zero.
    a_empty_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !r_win_valid) |-> (r_win_idx == '0))
        else $error("empty grant with nonzero id");

    // A written-back actor is marked as granted from the next cycle on.
    a_ever_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> r_ever[$past(o_wr_addr)])
        else $error("granted actor not marked");

    // The read counter never runs past the actor count.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_cnt <= CNT_W'(SCAN_N)))
        else $error("scan counter overrun");

endmodule

// File: hw/rtl/starvation_aware_oldest_first_arbiter.sv
// Starvation-aware oldest-first arbiter: one grant per request transfer. Each
// request names the requesting actors and the current time; requesters are
// examined in ascending id order and the first one never granted, or whose age
// exceeds the starvation limit, wins at once; otherwise the oldest requester
// wins, the lowest id on a tie. A request is taken in the idle state; the scan
// then reads one actor's last grant time per cycle from the single read port of
// the timestamp memory, up to min(NUM_ACTORS,16) actors, and ends early when a
// never-granted or starved actor wins. Each timestamp comes from the memory's
// registered read port and is evaluated as it arrives. The result is then handed
// on while the winner's timestamp is written back, and the block returns to idle
// for the next request.
// The finished result sits in an output register, so the next request is
// taken while it waits; a second result stays in the sequencer, and holds off
// further requests, until the output register is free again. The user is to
// write the starvation limit through its own port only while the block is idle;
// the block itself does not enforce it. The limit resets to 1000 ticks.
module starvation_aware_oldest_first_arbiter #(
    parameter int NUM_ACTORS = soarb_pkg::NUM_ACTORS_DEF,
    parameter int TIME_WIDTH = soarb_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [soarb_pkg::LIMIT_W-1:0]   i_cfg_data,
    // Request channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [soarb_pkg::MASK_W-1:0]    i_request_mask,
    input  logic [soarb_pkg::TIME_IN_W-1:0] i_now_time,
    // Grant channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_grant_valid,
    output logic [soarb_pkg::ID_W-1:0]      o_grant_id,
    output logic                            o_grant_reason
);

    localparam int SCAN_N = (NUM_ACTORS < soarb_pkg::MASK_W) ? NUM_ACTORS
                                                             : soarb_pkg::MASK_W;
    localparam int SIDX_W = $clog2(SCAN_N);

    logic [soarb_pkg::LIMIT_W-1:0] r_limit, n_limit;
    logic                          r_out_valid, n_out_valid;
    soarb_pkg::t_result            r_res, n_res;

    logic                  ctrl_idle;
    logic                  res_valid;
    soarb_pkg::t_result    res;
    logic                  res_take;
    logic                  start;
    logic                  rd_en;
    logic [SIDX_W-1:0]     rd_addr;
    logic [TIME_WIDTH-1:0] rd_data;
    logic                  wr_en;
    logic [SIDX_W-1:0]     wr_addr;
    logic [TIME_WIDTH-1:0] wr_data;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ctrl_idle;
    assign start       = i_in_valid && ctrl_idle;
    assign res_take    = res_valid && (!r_out_valid || i_out_ready);

    // Starvation limit register and output register next values.
    always_comb begin
        n_limit     = r_limit;
        n_out_valid = r_out_valid;
        n_res       = r_res;
        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end
        if (res_take) begin
            n_out_valid = 1'b1;
            n_res       = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= soarb_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Scan sequencer and decision.
    soarb_ctrl #(
        .NUM_ACTORS (NUM_ACTORS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mask      (i_request_mask),
        .i_now       (i_now_time),
        .i_limit     (r_limit),
        .o_idle      (ctrl_idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Last grant timestamp per actor.
    soarb_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (SCAN_N)
    ) u_time_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output ports.
    assign o_out_valid    = r_out_valid;
    assign o_grant_valid  = r_res.grant_valid;
    assign o_grant_id     = r_res.grant_id;
    assign o_grant_reason = r_res.grant_reason;

endmodule

// File: bench/starvation_aware_oldest_first_arbiter_test.sv
// Self-checking testbench for the starvation-aware oldest-first arbiter.
module starvation_aware_oldest_first_arbiter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACTORS = soarb_pkg::NUM_ACTORS_DEF;
    localparam int RANDOM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 136;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 25;

    // Kinds of rows in the directed plan.
    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_FIFTH,
        RX_MOSTLY
    } t_stall_mode;

    typedef struct {
        t_row_kind                         kind;
        logic [soarb_pkg::MASK_W-1:0]      mask;
        logic [soarb_pkg::TIME_IN_W-1:0]   value;
        bit                                check;
        soarb_pkg::t_result                want;
    } t_plan_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [soarb_pkg::LIMIT_W-1:0]     i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [soarb_pkg::MASK_W-1:0]      i_request_mask;
    logic [soarb_pkg::TIME_IN_W-1:0]   i_now_time;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic                              o_grant_valid;
    logic [soarb_pkg::ID_W-1:0]        o_grant_id;
    logic                              o_grant_reason;

    // Local copy of the arbiter state, the limit and the pending grants.
    logic [soarb_pkg::TIME_IN_W-1:0]   stamp_of [ACTORS];
    bit                                was_granted [ACTORS];
    logic [soarb_pkg::LIMIT_W-1:0]     starve_limit;
    soarb_pkg::t_result                grants_due [$];
    t_plan_row                         plan [$];

    int mismatches = 0;
    int grants_seen = 0;
    int hold_asks = 0;
    int holds_served = 0;
    int burst_left = 0;

    starvation_aware_oldest_first_arbiter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_request_mask (i_request_mask),
        .i_now_time     (i_now_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_grant_valid  (o_grant_valid),
        .o_grant_id     (o_grant_id),
        .o_grant_reason (o_grant_reason)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

    // Computes the grant for one request and updates the local state.
    function automatic soarb_pkg::t_result predict_grant(
        input logic [soarb_pkg::MASK_W-1:0] mask,
        input logic [soarb_pkg::TIME_IN_W-1:0] now_val);
        soarb_pkg::t_result              res;
        bit                              found;
        bit                              have_best;
        int                              best;
        logic [soarb_pkg::TIME_IN_W-1:0] best_age;
        logic [soarb_pkg::TIME_IN_W-1:0] age;
        res = '0;
        found = 1'b0;
        have_best = 1'b0;
        best = 0;
        best_age = '0;
        for (int i = 0; i < ACTORS; i++) begin
            if (!found && mask[i]) begin
                if (!was_granted[i]) begin
                    found = 1'b1;
                    best = i;
                end else begin
                    // Ages wrap modulo the time width.
                    age = now_val - stamp_of[i];
                    if (age > starve_limit) begin
                        found = 1'b1;
                        best = i;
                    end else if (!have_best || age > best_age) begin
                        have_best = 1'b1;
                        best = i;
                        best_age = age;
                    end
                end
            end
        end
        if (found || have_best) begin
            res.grant_valid = 1'b1;
            res.grant_id = best[soarb_pkg::ID_W-1:0];
            res.grant_reason = found ? soarb_pkg::REASON_FIRST : soarb_pkg::REASON_OLDEST;
            stamp_of[best] = now_val;
            was_granted[best] = 1'b1;
        end
        return res;
    endfunction

    // Mostly realistic masks, with sparse, dense, empty and noisy ones mixed in.
    function automatic logic [soarb_pkg::MASK_W-1:0] random_mask();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return 16'($urandom);
        else if (pick < 55)
            return 16'h0001 << $urandom_range(0, 15);
        else if (pick < 70)
            return (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15))
                | (16'h0001 << $urandom_range(0, 15));
        else if (pick < 80)
            return 16'hFFFF;
        else if (pick < 85)
            return 16'h0000;
        else
            return 16'($urandom & $urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [soarb_pkg::MASK_W-1:0] mask,
                           input logic [soarb_pkg::TIME_IN_W-1:0] value, input bit check,
                           input logic gv, input logic [soarb_pkg::ID_W-1:0] gid,
                           input logic reason);
        t_plan_row r;
        r.kind = kind;
        r.mask = mask;
        r.value = value;
        r.check = check;
        r.want.grant_valid = gv;
        r.want.grant_id = gid;
        r.want.grant_reason = reason;
        plan.push_back(r);
    endtask

    // Offers one request and records the grant it must produce once transferred.
    task automatic offer_request(input logic [soarb_pkg::MASK_W-1:0] mask,
                                 input logic [soarb_pkg::TIME_IN_W-1:0] now_val,
                                 input bit check, input soarb_pkg::t_result typed);
        soarb_pkg::t_result predicted;
        i_in_valid <= 1'b1;
        i_request_mask <= mask;
        i_now_time <= now_val;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_grant(mask, now_val);
        grants_due.push_back(check ? typed : predicted);
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : int'($urandom_range(0, 30));
        end
    endtask

    // Stops offering and waits until every pending grant has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [soarb_pkg::LIMIT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        starve_limit = value;
    endtask

    // Receiver: changing stall patterns, plus long hold-offs on request.
    initial begin
        t_stall_mode mode;
        int mode_left;
        int hold_left;
        int beat;
        i_out_ready = 1'b0;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        beat = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != holds_served) begin
                holds_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            beat++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:        i_out_ready <= 1'b1;
                    RX_COIN:        i_out_ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FIFTH: i_out_ready <= (beat % 5 == 0);
                    default:        i_out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Grant checker: each transfer is compared with the oldest pending grant.
    always @(posedge i_clk) begin : grant_check
        soarb_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grants_due.size() == 0) begin
                report_mismatch($sformatf("grant %0d arrived with none pending", grants_seen));
            end else begin
                want = grants_due.pop_front();
                if (o_grant_valid !== want.grant_valid)
                    report_mismatch($sformatf("grant %0d grant_valid %0b, expected %0b",
                        grants_seen, o_grant_valid, want.grant_valid));
                if (o_grant_id !== want.grant_id)
                    report_mismatch($sformatf("grant %0d grant_id %0d, expected %0d",
                        grants_seen, o_grant_id, want.grant_id));
                if (o_grant_reason !== want.grant_reason)
                    report_mismatch($sformatf("grant %0d grant_reason %0b, expected %0b",
                        grants_seen, o_grant_reason, want.grant_reason));
            end
            grants_seen++;
        end
    end

    // Stimulus: reset, directed plan, then random phases under several limits.
    initial begin
        logic [soarb_pkg::LIMIT_W-1:0]   phase_limit;
        logic [soarb_pkg::TIME_IN_W-1:0] tick;
        int                              step_span;
        int                              pick;
        soarb_pkg::t_result              none;
        none = '0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_request_mask = '0;
        i_now_time = '0;
        starve_limit = soarb_pkg::LIMIT_RESET;
        for (int i = 0; i < ACTORS; i++) begin
            stamp_of[i] = '0;
            was_granted[i] = 1'b0;
        end

        // Directed rows; the expected grant is typed in where it is obvious.
        add_row(ROW_REQ, 16'h0000, 32'd0, 1'b1, 1'b0, 4'd0, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h0001, 32'd0, 1'b1, 1'b1, 4'd0, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h8000, 32'd5, 1'b1, 1'b1, 4'd15, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h8001, 32'd10, 1'b1, 1'b1, 4'd0, soarb_pkg::REASON_OLDEST);
        add_row(ROW_REQ, 16'h8001, 32'd10, 1'b1, 1'b1, 4'd15, soarb_pkg::REASON_OLDEST);
        // Equal ages: the lowest id wins.
        add_row(ROW_REQ, 16'h8001, 32'd10, 1'b1, 1'b1, 4'd0, soarb_pkg::REASON_OLDEST);
        add_row(ROW_REQ, 16'hFFFF, 32'd20, 1'b1, 1'b1, 4'd1, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h0006, 32'd30, 1'b1, 1'b1, 4'd2, soarb_pkg::REASON_FIRST);
        // Age equal to the limit is not starvation; one past it is.
        add_row(ROW_REQ, 16'h8000, 32'd1010, 1'b1, 1'b1, 4'd15, soarb_pkg::REASON_OLDEST);
        add_row(ROW_REQ, 16'h0001, 32'd1011, 1'b1, 1'b1, 4'd0, soarb_pkg::REASON_FIRST);
        // Time wrapping around the top of the range.
        add_row(ROW_REQ, 16'h0002, 32'hFFFF_FFF0, 1'b1, 1'b1, 4'd1, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h0002, 32'h0000_0010, 1'b1, 1'b1, 4'd1, soarb_pkg::REASON_OLDEST);
        add_row(ROW_REQ, 16'h0006, 32'h0000_0010, 1'b1, 1'b1, 4'd2, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 4'd0, soarb_pkg::REASON_FIRST);
        // Zero limit: any nonzero age starves.
        add_row(ROW_CFG, 16'h0000, 32'd0, 1'b0, 1'b0, 4'd0, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h0002, 32'h0000_0010, 1'b1, 1'b1, 4'd1, soarb_pkg::REASON_OLDEST);
        add_row(ROW_REQ, 16'h0006, 32'h0000_0011, 1'b1, 1'b1, 4'd1, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h0006, 32'h0000_0011, 1'b1, 1'b1, 4'd2, soarb_pkg::REASON_FIRST);
        // Largest limit: nothing can ever starve.
        add_row(ROW_CFG, 16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h8001, 32'h0000_0000, 1'b1, 1'b1, 4'd15, soarb_pkg::REASON_OLDEST);
        add_row(ROW_REQ, 16'hFFF8, 32'h1234_5678, 1'b1, 1'b1, 4'd3, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h7FF0, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd4, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'hAAAA, 32'h5555_5555, 1'b0, 1'b0, 4'd0, soarb_pkg::REASON_FIRST);
        add_row(ROW_REQ, 16'h5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 4'd0, soarb_pkg::REASON_FIRST);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                wait_drained();
                write_limit(plan[k].value);
            end else begin
                offer_request(plan[k].mask, plan[k].value, plan[k].check, plan[k].want);
                pace_sender();
            end
        end

        // Random phases; time mostly creeps forward so ages straddle the limit.
        tick = $urandom;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       phase_limit = soarb_pkg::LIMIT_RESET;
                1:       phase_limit = '0;
                2:       phase_limit = '1;
                3:       phase_limit = $urandom_range(1, 50);
                4:       phase_limit = $urandom_range(100, 5000);
                5:       phase_limit = $urandom;
                default: phase_limit = soarb_pkg::LIMIT_RESET;
            endcase
            wait_drained();
            write_limit(phase_limit);
            step_span = (phase_limit <= 4096) ? int'(phase_limit) / 6 + 2 : 600;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Long receiver hold while requests keep coming.
                if (n == 40)
                    hold_asks++;
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    tick = $urandom;
                else if (pick >= 10)
                    tick = tick + $urandom_range(0, step_span);
                offer_request(random_mask(), tick, 1'b0, none);
                pace_sender();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
